>>> hdl/pbp_pkg.sv
// Shared types, constants and the arctangent table for the pixel bearing block.
package pbp_pkg;

   localparam int XY_W       = 33;   // CORDIC x/y, signed Q2.30 with headroom
   localparam int Z_W        = 34;   // residual angle, signed binary angle
   localparam int Q_W        = 33;   // quotient bits out of the bearing divider
   localparam int ANG_W      = 32;   // binary angle, full turn = 2^32
   localparam int ATAN_W     = 30;
   localparam int DIST_W     = 16;
   localparam int POS_W      = 18;
   localparam int WIDTH_W    = 13;
   localparam int ANGLE_W    = 16;
   localparam int CFG_IDX_W  = 2;
   localparam int CFG_DATA_W = 16;
   localparam int SCALE_W    = 17;
   localparam int PROD_W     = XY_W + SCALE_W;

   localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE   = 2'd1;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;
   localparam logic [ANGLE_W-1:0] ANGLE_RESET = 16'd7680;

   localparam logic [16:0]            DEG_Q8_PER_TURN = 17'd92160;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN     = 33'sd652032874;
   localparam logic [19:0]            POS_LIMIT       = 20'd65791;
   localparam logic [SCALE_W-1:0]     DIST_OFFSET     = 17'd256;
   localparam logic [PROD_W-1:0]      ROUND_HALF      = PROD_W'(64'd1 << 29);

   typedef struct packed {
      logic              neg;
      logic [DIST_W-1:0] distance;
   } div_side_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   flip;
      logic [DIST_W-1:0]      distance;
   } cordic_type;

   // atan(2^-i) in binary angle units, rounded to nearest
   function automatic logic [ATAN_W-1:0] atan_turn(input logic [4:0] idx);
      logic [ATAN_W-1:0] r;
      unique case (idx)
         5'd0:  r = 30'd536870912;
         5'd1:  r = 30'd316933406;
         5'd2:  r = 30'd167458907;
         5'd3:  r = 30'd85004756;
         5'd4:  r = 30'd42667331;
         5'd5:  r = 30'd21354465;
         5'd6:  r = 30'd10679838;
         5'd7:  r = 30'd5340245;
         5'd8:  r = 30'd2670163;
         5'd9:  r = 30'd1335087;
         5'd10: r = 30'd667544;
         5'd11: r = 30'd333772;
         5'd12: r = 30'd166886;
         5'd13: r = 30'd83443;
         5'd14: r = 30'd41722;
         5'd15: r = 30'd20861;
         5'd16: r = 30'd10430;
         5'd17: r = 30'd5215;
         5'd18: r = 30'd2608;
         5'd19: r = 30'd1304;
         5'd20: r = 30'd652;
         5'd21: r = 30'd326;
         5'd22: r = 30'd163;
         5'd23: r = 30'd81;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/pixel_bearing_to_position.sv
// Request to rsp_valid path: centering and ratio registers, the 33-cell divider chain,
// the fold register, the CORDIC cell chain, the scaling stages and the output register.
// Throughput: one request per cycle; req_ready drops only when the output register and
// the skid register both hold results.
// Reset (synchronous, active high) empties every stage and loads image_width = 640 and
// max_angle = 7680 (30.0 degrees).
module pixel_bearing_to_position #(
   parameter int CORDIC_STAGES = 16,
   parameter int COLUMN_BITS   = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [COLUMN_BITS-1:0]              req_pixel_column,
   input  logic [pbp_pkg::DIST_W-1:0]          req_distance,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pbp_pkg::POS_W-1:0]    rsp_side_position,
   output logic signed [pbp_pkg::POS_W-1:0]    rsp_front_position,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pbp_pkg::CFG_IDX_W-1:0]       csr_index,
   input  logic [pbp_pkg::CFG_DATA_W-1:0]      csr_data
);
   import pbp_pkg::*;

   // internal widths follow the column width
   localparam int WW      = (COLUMN_BITS + 1 > WIDTH_W) ? COLUMN_BITS + 1 : WIDTH_W;
   localparam int NUM_W   = COLUMN_BITS + ANGLE_W;
   localparam int DEN_W   = COLUMN_BITS + 17;
   localparam int DIV_N   = Q_W;

   // config registers
   logic [WIDTH_W-1:0] width_ff;
   logic [ANGLE_W-1:0] angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         angle_ff <= ANGLE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: width_ff <= csr_data[WIDTH_W-1:0];
            REG_MAX_ANGLE:   angle_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // pipeline advances unless the skid register is occupied
   logic skid_valid_ff;
   logic adv;
   assign adv       = !skid_valid_ff;
   assign req_ready = adv;

   // stage 0: width clamp, column clamp, centering
   logic [WW-1:0] w_eff, w_ext, w_limit, col_ext, col_c, half;
   logic [WW-1:0] mag_in;
   logic          neg_in;

   always_comb begin
      w_ext   = WW'(width_ff);
      w_limit = WW'(1) << COLUMN_BITS;
      if (w_ext == '0) begin
         w_eff = WW'(1);
      end else if (w_ext > w_limit) begin
         w_eff = w_limit;
      end else begin
         w_eff = w_ext;
      end
      col_ext = WW'(req_pixel_column);
      col_c   = (col_ext > w_eff - WW'(1)) ? w_eff - WW'(1) : col_ext;
      half    = (w_eff + WW'(1)) >> 1;
      if (col_c > half) begin
         neg_in = 1'b0;
         mag_in = col_c - half;
      end else begin
         neg_in = 1'b1;
         mag_in = half + WW'(1) - col_c;
      end
   end

   logic                   pre_valid_ff;
   logic [COLUMN_BITS-1:0] mag_ff, half_ff;
   div_side_type           pre_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (adv) begin
         pre_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff      <= COLUMN_BITS'(mag_in);
         half_ff     <= COLUMN_BITS'(half);
         pre_side_ff <= '{neg: neg_in, distance: req_distance};
      end
   end

   // stage 1: numerator and denominator of the bearing ratio
   logic             mul_valid_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   div_side_type     mul_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (adv) begin
         mul_valid_ff <= pre_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff      <= NUM_W'(mag_ff) * NUM_W'(angle_ff);
         den_ff      <= DEN_W'(half_ff) * DEN_W'(DEG_Q8_PER_TURN);
         mul_side_ff <= pre_side_ff;
      end
   end

   // divider chain: (num * 2^32 + den/2) / den, one quotient bit per cell
   logic [DIV_N:0]   dv_valid;
   logic [DEN_W-1:0] dv_rem  [0:DIV_N];
   logic [DEN_W-1:0] dv_den  [0:DIV_N];
   logic [Q_W-1:0]   dv_bits [0:DIV_N];
   logic [Q_W-1:0]   dv_q    [0:DIV_N];
   div_side_type     dv_side [0:DIV_N];

   assign dv_valid[0] = mul_valid_ff;
   assign dv_rem[0]   = DEN_W'(num_ff >> 1);
   assign dv_den[0]   = den_ff;
   assign dv_bits[0]  = {num_ff[0], 32'(den_ff >> 1)};
   assign dv_q[0]     = '0;
   assign dv_side[0]  = mul_side_ff;

   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      pbp_div_cell #(.DEN_W(DEN_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (adv),
         .in_valid (dv_valid[k]),
         .rem_in   (dv_rem[k]),
         .den_in   (dv_den[k]),
         .bits_in  (dv_bits[k]),
         .q_in     (dv_q[k]),
         .side_in  (dv_side[k]),
         .out_valid(dv_valid[k+1]),
         .rem_out  (dv_rem[k+1]),
         .den_out  (dv_den[k+1]),
         .bits_out (dv_bits[k+1]),
         .q_out    (dv_q[k+1]),
         .side_out (dv_side[k+1])
      );
   end

   // fold stage: sign, then quadrants two and three rotate by a half turn
   logic [ANG_W-1:0] ang, ang_f;
   logic             flip;

   always_comb begin
      ang   = dv_side[DIV_N].neg ? -dv_q[DIV_N][ANG_W-1:0] : dv_q[DIV_N][ANG_W-1:0];
      flip  = ang[ANG_W-1] ^ ang[ANG_W-2];
      ang_f = {ang[ANG_W-1] ^ flip, ang[ANG_W-2:0]};
   end

   logic [CORDIC_STAGES:0] cv_valid;
   cordic_type             cv_cell [0:CORDIC_STAGES];
   logic                   fold_valid_ff;
   cordic_type             fold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (adv) begin
         fold_valid_ff <= dv_valid[DIV_N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fold_ff <= '{x: CORDIC_GAIN, y: '0, z: Z_W'(signed'(ang_f)),
                      flip: flip, distance: dv_side[DIV_N].distance};
      end
   end

   assign cv_valid[0] = fold_valid_ff;
   assign cv_cell[0]  = fold_ff;

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
      pbp_cordic_cell #(.IDX(s)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (adv),
         .in_valid (cv_valid[s]),
         .cell_in  (cv_cell[s]),
         .out_valid(cv_valid[s+1]),
         .cell_out (cv_cell[s+1])
      );
   end

   // scaling by distance + 1.0, two stages
   logic                    scale_a_valid_ff, scale_b_valid_ff;
   logic signed [POS_W-1:0] side_pos, front_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_a_valid_ff <= 1'b0;
         scale_b_valid_ff <= 1'b0;
      end else if (adv) begin
         scale_a_valid_ff <= cv_valid[CORDIC_STAGES];
         scale_b_valid_ff <= scale_a_valid_ff;
      end
   end

   pbp_scale u_side (
      .clock   (clock),
      .enable  (adv),
      .value   (cv_cell[CORDIC_STAGES].y),
      .flip    (cv_cell[CORDIC_STAGES].flip),
      .distance(cv_cell[CORDIC_STAGES].distance),
      .pos     (side_pos)
   );

   pbp_scale u_front (
      .clock   (clock),
      .enable  (adv),
      .value   (cv_cell[CORDIC_STAGES].x),
      .flip    (cv_cell[CORDIC_STAGES].flip),
      .distance(cv_cell[CORDIC_STAGES].distance),
      .pos     (front_pos)
   );

   // output register plus skid register
   logic                    out_valid_ff;
   logic signed [POS_W-1:0] out_side_ff, out_front_ff, skid_side_ff, skid_front_ff;
   logic                    push, pop;

   assign push = scale_b_valid_ff & adv;
   assign pop  = out_valid_ff & rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop || !out_valid_ff) begin
         out_valid_ff  <= skid_valid_ff | push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_side_ff  <= skid_side_ff;
            out_front_ff <= skid_front_ff;
         end else begin
            out_side_ff  <= side_pos;
            out_front_ff <= front_pos;
         end
      end else if (push) begin
         skid_side_ff  <= side_pos;
         skid_front_ff <= front_pos;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_side_position  = out_side_ff;
   assign rsp_front_position = out_front_ff;

endmodule

>>> hdl/pbp_div_cell.sv
// One restoring-division cell: retires one quotient bit per request per cycle while enabled.
module pbp_div_cell #(
   parameter int DEN_W = 29
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  logic [DEN_W-1:0]          rem_in,
   input  logic [DEN_W-1:0]          den_in,
   input  logic [pbp_pkg::Q_W-1:0]   bits_in,
   input  logic [pbp_pkg::Q_W-1:0]   q_in,
   input  pbp_pkg::div_side_type     side_in,
   output logic                      out_valid,
   output logic [DEN_W-1:0]          rem_out,
   output logic [DEN_W-1:0]          den_out,
   output logic [pbp_pkg::Q_W-1:0]   bits_out,
   output logic [pbp_pkg::Q_W-1:0]   q_out,
   output pbp_pkg::div_side_type     side_out
);
   import pbp_pkg::*;

   logic             valid_ff;
   logic [DEN_W-1:0] rem_ff, rem_in_nx;
   logic [DEN_W-1:0] den_ff;
   logic [Q_W-1:0]   bits_ff, q_ff;
   div_side_type     side_ff;
   logic [DEN_W:0]   trial, diff;
   logic             ge;

   always_comb begin
      trial     = {rem_in, bits_in[Q_W-1]};
      diff      = trial - {1'b0, den_in};
      ge        = trial >= {1'b0, den_in};
      rem_in_nx = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in_nx;
         den_ff  <= den_in;
         bits_ff <= {bits_in[Q_W-2:0], 1'b0};
         q_ff    <= {q_in[Q_W-2:0], ge};
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign rem_out   = rem_ff;
   assign den_out   = den_ff;
   assign bits_out  = bits_ff;
   assign q_out     = q_ff;
   assign side_out  = side_ff;

endmodule

>>> hdl/pbp_cordic_cell.sv
// One CORDIC rotation cell with a fixed shift and arctangent step.
module pbp_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  pbp_pkg::cordic_type  cell_in,
   output logic                 out_valid,
   output pbp_pkg::cordic_type  cell_out
);
   import pbp_pkg::*;

   logic                   valid_ff;
   cordic_type             cell_ff, cell_in_nx;
   logic signed [XY_W-1:0] dx, dy;
   logic signed [Z_W-1:0]  step;

   always_comb begin
      dx         = cell_in.y >>> IDX;
      dy         = cell_in.x >>> IDX;
      step       = signed'(Z_W'(atan_turn(5'(IDX))));
      cell_in_nx = cell_in;
      if (!cell_in.z[Z_W-1]) begin
         cell_in_nx.x = cell_in.x - dx;
         cell_in_nx.y = cell_in.y + dy;
         cell_in_nx.z = cell_in.z - step;
      end else begin
         cell_in_nx.x = cell_in.x + dx;
         cell_in_nx.y = cell_in.y - dy;
         cell_in_nx.z = cell_in.z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cell_ff <= cell_in_nx;
      end
   end

   assign out_valid = valid_ff;
   assign cell_out  = cell_ff;

endmodule

>>> hdl/pbp_scale.sv
// Two-stage scaling of a unit vector component by distance, with rounding and clamp.
module pbp_scale (
   input  logic                              clock,
   input  logic                              enable,
   input  logic signed [pbp_pkg::XY_W-1:0]   value,
   input  logic                              flip,
   input  logic [pbp_pkg::DIST_W-1:0]        distance,
   output logic signed [pbp_pkg::POS_W-1:0]  pos
);
   import pbp_pkg::*;

   logic                    neg_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [XY_W-1:0]         mag;
   logic [PROD_W-1:0]       rounded;
   logic [19:0]             sat;
   logic signed [POS_W-1:0] pos_ff, pos_in;

   always_comb begin
      mag     = value[XY_W-1] ? XY_W'(-value) : XY_W'(value);
      rounded = (prod_ff + ROUND_HALF) >> 30;
      sat     = (rounded > PROD_W'(POS_LIMIT)) ? POS_LIMIT : rounded[19:0];
      pos_in  = neg_ff ? -signed'(POS_W'(sat)) : signed'(POS_W'(sat));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         neg_ff  <= value[XY_W-1] ^ flip;
         prod_ff <= PROD_W'(mag) * PROD_W'(SCALE_W'(distance) + DIST_OFFSET);
         pos_ff  <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

>>> hdl/pbp_checker.sv
// Port-level checks for the pixel bearing block and their bind.
module pbp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [pbp_pkg::POS_W-1:0]  rsp_side_position,
   input logic signed [pbp_pkg::POS_W-1:0]  rsp_front_position
);
   import pbp_pkg::*;

   localparam logic signed [POS_W-1:0] POS_MAX = 18'sd65791;
   localparam logic signed [POS_W-1:0] POS_MIN = -18'sd65791;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_side_position)
                                  && $stable(rsp_front_position))
      else $error("stalled response changed");

   a_side_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_side_position <= POS_MAX && rsp_side_position >= POS_MIN)
      else $error("side position out of range");

   a_front_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_front_position <= POS_MAX && rsp_front_position >= POS_MIN)
      else $error("front position out of range");

   a_full_means_pending: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no pending response");

endmodule

bind pixel_bearing_to_position pbp_checker u_checker (.*);
